>>> sv/wpwm_pkg.sv
// ----------------------------------------------------------------------------
// wpwm_pkg
// shared types and constants for the word permutation window matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wpwm_pkg;

	localparam int MAX_WORD_LEN_DEF   = 16;
	localparam int MAX_WORDS_DEF      = 16;
	localparam int POSITION_WIDTH_DEF = 16;

	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int KIND_W      = 2;
	localparam int BYTE_W      = 8;
	localparam int MATCH_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WORD_LENGTH = 1'b0,
		REG_WORD_COUNT  = 1'b1
	} reg_index_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DICT = 2'd0,
		KIND_TEXT = 2'd1,
		KIND_NEW  = 2'd2,
		KIND_NOP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_CMP,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

>>> sv/wpwm_ram.sv
// ----------------------------------------------------------------------------
// wpwm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module wpwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> sv/word_permutation_window_matcher.sv
// ----------------------------------------------------------------------------
// word_permutation_window_matcher
// reports text offsets whose window is a permutation of the dictionary words
// ----------------------------------------------------------------------------
// Dictionary bytes (kind 0) are appended to a dictionary ram; text bytes
// (kind 1) go into a ring window ram, and once word_length*word_count bytes
// are held each text byte starts a check. The check walks chunk by chunk,
// trying each unclaimed word byte by byte through both rams: every byte
// compare passes ST_ISSUE (address) and then ST_CMP (registered read data),
// so a text byte goes through at once when no check runs, while one that
// starts a check holds in_stall high until the check and its result are
// through. Dictionary and new-text beats never start a check. One beat is
// worked at a time; a result waits in the output register while the next beat is taken.
`default_nettype none

module word_permutation_window_matcher #(
	parameter int MAX_WORD_LEN   = wpwm_pkg::MAX_WORD_LEN_DEF,
	parameter int MAX_WORDS      = wpwm_pkg::MAX_WORDS_DEF,
	parameter int POSITION_WIDTH = wpwm_pkg::POSITION_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [wpwm_pkg::KIND_W-1:0]   kind,
	input  wire logic [wpwm_pkg::BYTE_W-1:0]   data_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [wpwm_pkg::MATCH_W-1:0]  match_start,
	input  wire logic                          cfg_we,
	input  wire logic [wpwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wpwm_pkg::CFG_W-1:0]    cfg_data
);

	import wpwm_pkg::*;

	localparam int DEPTH = MAX_WORD_LEN * MAX_WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int LW    = $clog2(MAX_WORD_LEN + 1);
	localparam int CW    = $clog2(MAX_WORDS + 1);
	localparam int BI    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int WI    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int PW    = POSITION_WIDTH + 1;

	state_t state_q, state_d;

	logic [CFG_W-1:0] wl_cfg_q, wc_cfg_q;
	logic [FW-1:0]    fill_q;
	logic [PW-1:0]    pos_q;
	logic [AW-1:0]    wp_q;

	logic [AW-1:0]    chunk_q, bptr_q;
	logic [AW:0]      wbase_q, dptr_q;
	logic [WI-1:0]    c_q, w_q;
	logic [BI-1:0]    b_q;
	logic [MAX_WORDS-1:0] claimed_q;
	logic [PW-1:0]    start_q;

	logic                out_valid_q;
	logic [MATCH_W-1:0]  match_start_q;

	logic [LW-1:0] wl;
	logic [CW-1:0] wc;
	logic [FW-1:0] span;
	logic [BYTE_W-1:0] win_rd, dict_rd;

	logic accept, is_text, is_dict, is_new, sat, full_win;
	logic [PW:0]   pos_inc;
	logic [AW:0]   wp_sum, st_tmp, chunk_sum, bptr_sum;
	logic [AW-1:0] wp_next, start_mod, chunk_next, bptr_next;
	logic last_word, last_chunk, last_byte, eq, out_load;

	// clamp sizes into their legal ranges
	always_comb begin
		if (wl_cfg_q == '0) wl = LW'(1);
		else if (32'(wl_cfg_q) > MAX_WORD_LEN) wl = LW'(MAX_WORD_LEN);
		else wl = LW'(wl_cfg_q);
		if (wc_cfg_q == '0) wc = CW'(1);
		else if (32'(wc_cfg_q) > MAX_WORDS) wc = CW'(MAX_WORDS);
		else wc = CW'(wc_cfg_q);
	end

	assign span = FW'(FW'(wl) * FW'(wc));

	assign accept  = in_valid && !in_stall;
	assign is_dict = (kind == KIND_DICT);
	assign is_text = (kind == KIND_TEXT);
	assign is_new  = (kind == KIND_NEW);
	assign sat     = pos_q[PW-1];
	assign pos_inc = {1'b0, pos_q} + (PW+1)'(1);
	assign full_win = pos_inc >= (PW+1)'(span);

	assign wp_sum  = {1'b0, wp_q} + (AW+1)'(1);
	assign wp_next = (wp_sum >= (AW+1)'(DEPTH)) ? '0 : wp_sum[AW-1:0];
	// start of window modulo the ring depth
	assign st_tmp    = {1'b0, wp_next} + (AW+1)'(DEPTH) - (AW+1)'(span);
	assign start_mod = (st_tmp >= (AW+1)'(DEPTH)) ?
		AW'(st_tmp - (AW+1)'(DEPTH)) : st_tmp[AW-1:0];

	assign chunk_sum  = {1'b0, chunk_q} + (AW+1)'(wl);
	assign chunk_next = (chunk_sum >= (AW+1)'(DEPTH)) ?
		AW'(chunk_sum - (AW+1)'(DEPTH)) : chunk_sum[AW-1:0];
	assign bptr_sum   = {1'b0, bptr_q} + (AW+1)'(1);
	assign bptr_next  = (bptr_sum >= (AW+1)'(DEPTH)) ? '0 : bptr_sum[AW-1:0];

	assign last_word  = (CW'(w_q) + CW'(1)) == wc;
	assign last_chunk = (CW'(c_q) + CW'(1)) == wc;
	assign last_byte  = (LW'(b_q) + LW'(1)) == wl;
	assign eq         = (win_rd == dict_rd);

	assign out_load = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);

	wpwm_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH), .AW(AW)) u_dict_ram (
		.clk   (clk),
		.we    (accept && is_dict && (fill_q < FW'(DEPTH))),
		.waddr (fill_q[AW-1:0]),
		.wdata (data_byte),
		.raddr (dptr_q[AW-1:0]),
		.rdata (dict_rd)
	);

	wpwm_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH), .AW(AW)) u_win_ram (
		.clk   (clk),
		.we    (accept && is_text && !sat),
		.waddr (wp_q),
		.wdata (data_byte),
		.raddr (bptr_q),
		.rdata (win_rd)
	);

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_text && !sat && full_win) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (claimed_q[w_q]) begin
					if (last_word) state_d = ST_IDLE;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (!eq) state_d = last_word ? ST_IDLE : ST_ISSUE;
				else if (last_byte && last_chunk) state_d = ST_RESULT;
				else state_d = ST_ISSUE;
			end
			ST_RESULT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wl_cfg_q    <= CFG_W'(1);
			wc_cfg_q    <= CFG_W'(1);
			fill_q      <= '0;
			pos_q       <= '0;
			wp_q        <= '0;
			claimed_q   <= '0;
			c_q         <= '0;
			w_q         <= '0;
			b_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_WORD_LENGTH: wl_cfg_q <= cfg_data;
					REG_WORD_COUNT:  wc_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_dict && (fill_q < FW'(DEPTH))) fill_q <= fill_q + FW'(1);
						if (is_new) begin
							pos_q <= '0;
							wp_q  <= '0;
						end
						if (is_text && !sat) begin
							pos_q <= pos_inc[PW-1:0];
							wp_q  <= wp_next;
							if (full_win) begin
								chunk_q   <= start_mod;
								bptr_q    <= start_mod;
								wbase_q   <= '0;
								dptr_q    <= '0;
								c_q       <= '0;
								w_q       <= '0;
								b_q       <= '0;
								claimed_q <= '0;
								start_q   <= PW'(pos_inc - (PW+1)'(span));
							end
						end
					end
				end
				ST_ISSUE: begin
					// claimed word: move straight on to the next one
					if (claimed_q[w_q] && !last_word) begin
						w_q     <= w_q + WI'(1);
						wbase_q <= wbase_q + (AW+1)'(wl);
						dptr_q  <= wbase_q + (AW+1)'(wl);
						bptr_q  <= chunk_q;
						b_q     <= '0;
					end
				end
				ST_CMP: begin
					if (!eq) begin
						if (!last_word) begin
							w_q     <= w_q + WI'(1);
							wbase_q <= wbase_q + (AW+1)'(wl);
							dptr_q  <= wbase_q + (AW+1)'(wl);
							bptr_q  <= chunk_q;
							b_q     <= '0;
						end
					end else if (last_byte) begin
						claimed_q[w_q] <= 1'b1;
						if (!last_chunk) begin
							c_q     <= c_q + WI'(1);
							chunk_q <= chunk_next;
							bptr_q  <= chunk_next;
							w_q     <= '0;
							wbase_q <= '0;
							dptr_q  <= '0;
							b_q     <= '0;
						end
					end else begin
						b_q    <= b_q + BI'(1);
						bptr_q <= bptr_next;
						dptr_q <= dptr_q + (AW+1)'(1);
					end
				end
				ST_RESULT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) match_start_q <= MATCH_W'(start_q);
	end

	assign out_valid   = out_valid_q;
	assign match_start = match_start_q;

	// one claimed word per finished chunk
	a_claim_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE || state_q == ST_CMP) |-> $countones(claimed_q) == 32'(c_q))
		else $error("claimed words out of step with chunk count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("dictionary fill beyond depth");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (CW'(w_q) < wc) && (LW'(b_q) < wl))
		else $error("word or byte index beyond configured size");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && out_valid_q && out_stall) |=> state_q == ST_RESULT)
		else $error("result dropped while output held");

endmodule

`default_nettype wire
